FILE: hdl/afd_pkg.sv
// Shared types and constants for the API frame deframer.
package afd_pkg;

    localparam int unsigned PADDR_W = 2;
    localparam int unsigned PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_FRAME_TYPE = 2'd0;

    localparam logic [7:0] START_BYTE       = 8'h7E;
    localparam logic [7:0] FRAME_TYPE_RESET = 8'hB0;
    localparam int unsigned FIRST_STORED_POS = 14;
    localparam int unsigned INDEX_W = 10;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_OK        = 3'd1,
        EV_NOT_START = 3'd2,
        EV_BAD_LEN   = 3'd3,
        EV_BAD_TYPE  = 3'd4,
        EV_BAD_SUM   = 3'd5
    } t_event;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_stage;

endpackage

FILE: hdl/afd_if.sv
// Channel interfaces: received bytes in, deframed results out.
interface afd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface afd_res_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [9:0] payload_index;
    logic [2:0] event_res;

    modport source (output valid, output payload_valid, output payload_byte,
                    output payload_index, output event_res, input ready);
    modport sink (input valid, input payload_valid, input payload_byte,
                  input payload_index, input event_res, output ready);
endinterface

FILE: hdl/api_frame_deframer.sv
// Top level of the API frame deframer.
//
//  channel  | dir | handshake        | payload
//  i_rx     | in  | valid / ready    | rx_byte
//  o_res    | out | valid / ready    | payload_valid, payload_byte, payload_index, event_res
//  APB      | in  | psel / penable   | paddr, pwdata, prdata (expected_frame_type at 0x0)
//
// Each byte passes through the input register, then through the frame decode into the
// result register. One byte is accepted per cycle while results are taken. A stalled
// result holds the decode; the input register holds one byte, and ready drops once it
// is full. Synchronous reset returns the parser to start-byte hunting and the frame
// type register to 0xB0.
module api_frame_deframer #(
    parameter int unsigned MAX_FRAME_LEN = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    afd_rx_if.sink                      i_rx,
    afd_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [afd_pkg::PADDR_W-1:0] paddr,
    input  logic [afd_pkg::PDATA_W-1:0] pwdata,
    output logic [afd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import afd_pkg::*;

    t_stage     stage;
    logic       take;
    logic [7:0] frame_type;

    afd_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_frame_type (frame_type)
    );

    afd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_stage (stage)
    );

    afd_parse #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (stage),
        .i_frame_type (frame_type),
        .o_take       (take),
        .o_res        (o_res)
    );
endmodule

FILE: hdl/afd_cfg.sv
// APB register file holding the expected frame type.
module afd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [afd_pkg::PADDR_W-1:0] paddr,
    input  logic [afd_pkg::PDATA_W-1:0] pwdata,
    output logic [afd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [7:0]                  o_frame_type
);
    import afd_pkg::*;

    logic [7:0] r_frame_type;
    logic       wr_type;

    assign pready  = 1'b1;
    assign wr_type = psel && penable && pwrite && (paddr == REG_FRAME_TYPE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_type <= FRAME_TYPE_RESET;
        end else if (wr_type) begin
            r_frame_type <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_FRAME_TYPE) begin
            prdata = {{(PDATA_W-8){1'b0}}, r_frame_type};
        end
    end

    assign o_frame_type = r_frame_type;
endmodule

FILE: hdl/afd_in_stage.sv
// Input register that captures one received byte per item.
module afd_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    afd_rx_if.sink          i_rx,
    input  logic            i_take,
    output afd_pkg::t_stage o_stage
);
    import afd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
        if (i_rx.ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.rx_byte = r_byte;
endmodule

FILE: hdl/afd_parse.sv
// Frame state, per-byte decode and the result register.
module afd_parse #(
    parameter int unsigned MAX_FRAME_LEN = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  afd_pkg::t_stage i_stage,
    input  logic [7:0]      i_frame_type,
    output logic            o_take,
    afd_res_if.source       o_res
);
    import afd_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_FRAME_LEN + 3);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_sum, n_sum;

    logic             r_out_valid;
    logic             r_pl_valid, n_pl_valid;
    logic [7:0]       r_pl_byte, n_pl_byte;
    logic [9:0]       r_pl_index, n_pl_index;
    t_event           r_event, n_event;

    logic [15:0]      len_full;
    logic [16:0]      trailer_pos;
    logic [16:0]      pos_ext;
    logic [16:0]      index_diff;
    logic [7:0]       b;

    assign o_take = i_stage.valid && (!r_out_valid || o_res.ready);

    assign b           = i_stage.rx_byte;
    assign len_full    = {r_len[15:8], b};
    assign pos_ext     = 17'(r_pos);
    assign trailer_pos = {1'b0, r_len} + 17'd3;
    assign index_diff  = pos_ext - 17'(FIRST_STORED_POS);

    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_sum      = r_sum;
        n_pl_valid = 1'b0;
        n_pl_byte  = '0;
        n_pl_index = '0;
        n_event    = EV_NONE;
        if (r_pos == '0) begin
            if (b == START_BYTE) begin
                n_pos = POS_W'(1);
                n_len = '0;
                n_sum = '0;
            end else begin
                n_event = EV_NOT_START;
            end
        end else if (r_pos == POS_W'(1)) begin
            n_len = {b, 8'h00};
            n_pos = POS_W'(2);
        end else if (r_pos == POS_W'(2)) begin
            n_len = len_full;
            if ((len_full == '0) || ({1'b0, len_full} >= 17'(MAX_FRAME_LEN))) begin
                n_event = EV_BAD_LEN;
                n_pos   = '0;
            end else begin
                n_pos = POS_W'(3);
            end
        end else if (r_pos == POS_W'(3)) begin
            if (b == i_frame_type) begin
                n_sum = r_sum + b;
                n_pos = POS_W'(4);
            end else begin
                n_event = EV_BAD_TYPE;
                n_pos   = '0;
            end
        end else if (pos_ext >= trailer_pos) begin
            // The trailer closes the frame whatever the checksum says.
            n_event = (b == ~r_sum) ? EV_OK : EV_BAD_SUM;
            n_pos   = '0;
        end else begin
            n_sum = r_sum + b;
            if (pos_ext >= 17'(FIRST_STORED_POS)) begin
                n_pl_valid = 1'b1;
                n_pl_byte  = b;
                n_pl_index = index_diff[INDEX_W-1:0];
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_pos <= n_pos;
                r_len <= n_len;
                r_sum <= n_sum;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_take) begin
            r_pl_valid <= n_pl_valid;
            r_pl_byte  <= n_pl_byte;
            r_pl_index <= n_pl_index;
            r_event    <= n_event;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.payload_valid = r_pl_valid;
    assign o_res.payload_byte  = r_pl_byte;
    assign o_res.payload_index = r_pl_index;
    assign o_res.event_res     = r_event;
endmodule

FILE: hdl/afd_checker.sv
// Port-level checks for the API frame deframer and their binding.
module afd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        payload_valid,
    input logic [7:0]                  payload_byte,
    input logic [9:0]                  payload_index,
    input logic [2:0]                  event_res,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [afd_pkg::PADDR_W-1:0] paddr,
    input logic [afd_pkg::PDATA_W-1:0] pwdata,
    input logic [afd_pkg::PDATA_W-1:0] prdata
);
    import afd_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable({payload_valid, payload_byte,
            payload_index, event_res}))
        else $error("result changed while stalled");

    // A streamed payload byte never carries a frame event.
    a_payload_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && payload_valid |-> event_res == EV_NONE)
        else $error("payload byte with an event");

    // Without a payload byte, the byte and index fields are zero.
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !payload_valid |-> payload_byte == 8'h00 && payload_index == 10'd0)
        else $error("payload fields set without payload_valid");

    // Event codes stay within the defined set.
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> event_res <= EV_BAD_SUM)
        else $error("undefined event code");

    // A written frame type reads back.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr == REG_FRAME_TYPE
        |=> paddr != REG_FRAME_TYPE || prdata[7:0] == $past(pwdata[7:0]))
        else $error("frame type readback mismatch");
endmodule

bind api_frame_deframer afd_checker u_afd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .res_valid     (o_res.valid),
    .res_ready     (o_res.ready),
    .payload_valid (o_res.payload_valid),
    .payload_byte  (o_res.payload_byte),
    .payload_index (o_res.payload_index),
    .event_res     (o_res.event_res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

FILE: sim/tb_api_frame_deframer.sv
// Self-checking testbench for the API frame deframer: byte streams in, deframed results checked.
`timescale 1ns / 1ps

module tb_api_frame_deframer;
    import afd_pkg::*;

    localparam int unsigned FRAME_LEN_MAX = 1024;
    localparam int unsigned DIRECTED_N    = 25;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned HOLD_OFF_LEN  = 300;

    typedef struct packed {
        logic       pvalid;
        logic [7:0] pbyte;
        logic [9:0] pindex;
        t_event     ev;
    } t_result;

    // A byte to send; fixed rows carry an event read straight off the frame format.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       fixed;
        t_event     ev;
    } t_rx_item;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    afd_rx_if  rx_ch ();
    afd_res_if res_ch ();

    api_frame_deframer #(
        .MAX_FRAME_LEN(FRAME_LEN_MAX)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state.
    logic [10:0] frm_pos = '0;
    logic [15:0] frm_len = '0;
    logic [7:0]  frm_sum = '0;
    logic [7:0]  frame_type_cfg = FRAME_TYPE_RESET;

    t_rx_item    rx_stream[$];
    t_result     pending_results[$];
    t_rx_item    accepted_item;
    t_result     predicted;
    t_result     oldest;
    int unsigned error_cnt = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_off_left = 0;

    t_rx_item directed_rows [DIRECTED_N] = '{
        '{8'h00,      1'b1, EV_NOT_START},
        '{8'hFF,      1'b1, EV_NOT_START},
        '{START_BYTE, 1'b1, EV_NONE},
        '{8'h00,      1'b1, EV_NONE},
        '{8'h00,      1'b1, EV_BAD_LEN},
        '{START_BYTE, 1'b1, EV_NONE},
        '{8'h04,      1'b1, EV_NONE},
        '{8'h00,      1'b1, EV_BAD_LEN},
        '{START_BYTE, 1'b1, EV_NONE},
        '{8'hFF,      1'b1, EV_NONE},
        '{8'hFF,      1'b1, EV_BAD_LEN},
        '{START_BYTE, 1'b1, EV_NONE},
        '{8'h00,      1'b0, EV_NONE},
        '{8'h02,      1'b0, EV_NONE},
        '{8'hB1,      1'b1, EV_BAD_TYPE},
        '{START_BYTE, 1'b1, EV_NONE},
        '{8'h00,      1'b1, EV_NONE},
        '{8'h01,      1'b1, EV_NONE},
        '{8'hB0,      1'b1, EV_NONE},
        '{8'h4F,      1'b1, EV_OK},
        '{START_BYTE, 1'b1, EV_NONE},
        '{8'h00,      1'b1, EV_NONE},
        '{8'h01,      1'b1, EV_NONE},
        '{8'hB0,      1'b1, EV_NONE},
        '{8'h00,      1'b1, EV_BAD_SUM}
    };

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        r.ev = EV_NONE;
        if (frm_pos == 0) begin
            if (b == START_BYTE) begin
                frm_pos = 11'd1;
                frm_len = '0;
                frm_sum = '0;
            end else begin
                r.ev = EV_NOT_START;
            end
        end else if (frm_pos == 1) begin
            frm_len = {b, 8'h00};
            frm_pos = 11'd2;
        end else if (frm_pos == 2) begin
            frm_len = frm_len + b;
            if (frm_len == 0 || frm_len >= FRAME_LEN_MAX) begin
                r.ev = EV_BAD_LEN;
                frm_pos = '0;
            end else begin
                frm_pos = 11'd3;
            end
        end else if (frm_pos == 3) begin
            if (b == frame_type_cfg) begin
                frm_sum = frm_sum + b;
                frm_pos = 11'd4;
            end else begin
                r.ev = EV_BAD_TYPE;
                frm_pos = '0;
            end
        end else if (frm_pos >= frm_len + 3) begin
            r.ev = (b == 8'(8'hFF - frm_sum)) ? EV_OK : EV_BAD_SUM;
            frm_pos = '0;
        end else begin
            frm_sum = frm_sum + b;
            // The ten header bytes after the type are summed but never delivered.
            if (frm_pos >= FIRST_STORED_POS) begin
                r.pvalid = 1'b1;
                r.pbyte = b;
                r.pindex = 10'(frm_pos - FIRST_STORED_POS);
            end
            frm_pos = frm_pos + 11'd1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
        error_cnt++;
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                accepted_item = rx_stream.pop_front();
                predicted = deframe_byte(rx_ch.rx_byte);
                if (accepted_item.fixed) begin
                    predicted = '0;
                    predicted.ev = accepted_item.ev;
                end
                pending_results.push_back(predicted);
            end
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    oldest = pending_results.pop_front();
                    if (res_ch.payload_valid !== oldest.pvalid)
                        report_mismatch("payload_valid", res_ch.payload_valid, oldest.pvalid);
                    if (res_ch.payload_byte !== oldest.pbyte)
                        report_mismatch("payload_byte", res_ch.payload_byte, oldest.pbyte);
                    if (res_ch.payload_index !== oldest.pindex)
                        report_mismatch("payload_index", res_ch.payload_index, oldest.pindex);
                    if (res_ch.event_res !== oldest.ev)
                        report_mismatch("event_res", res_ch.event_res, oldest.ev);
                end
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_api_frame_deframer failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a counted hold-off that lets the block fill up.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_left > 0) begin
                res_ch.ready = 1'b0;
                hold_off_left--;
            end else begin
                res_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_frame_type(input logic [7:0] want);
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b0, REG_FRAME_TYPE, '0, rdata);
        if (rdata[7:0] !== want)
            report_mismatch("expected_frame_type readback", rdata[7:0], want);
    endtask

    task automatic set_frame_type(input logic [7:0] value);
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b1, REG_FRAME_TYPE, PDATA_W'(value), rdata);
        frame_type_cfg = value;
        check_frame_type(value);
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_rx_item it;
        it.rx_byte = b;
        it.fixed = 1'b0;
        it.ev = EV_NONE;
        rx_stream.push_back(it);
    endtask

    // A frame of len bytes counting the type; only cut payload bytes are sent when cut < len.
    task automatic push_frame(input int unsigned len, input logic [7:0] ftype,
                              input bit good_sum, input int unsigned cut);
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned k;
        push_byte(START_BYTE);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        push_byte(ftype);
        sum = ftype;
        for (k = 1; k < len && k <= cut; k++) begin
            b = 8'($urandom_range(255));
            sum = sum + b;
            push_byte(b);
        end
        if (cut >= len)
            push_byte(good_sum ? 8'(8'hFF - sum) : 8'($urandom_range(255)));
    endtask

    task automatic fill_traffic(input int unsigned n);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        target = rx_stream.size() + n;
        while (rx_stream.size() < target) begin
            pick = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(12, 200) : $urandom_range(1, 40);
            if (pick < 70) begin
                push_frame(len, frame_type_cfg, $urandom_range(99) < 85, len);
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
            end else if (pick < 84) begin
                push_byte(START_BYTE);
                if ($urandom_range(1) == 0) begin
                    push_byte(8'h00);
                    push_byte(8'h00);
                end else begin
                    push_byte(8'($urandom_range(4, 255)));
                    push_byte(8'($urandom_range(255)));
                end
            end else if (pick < 90) begin
                push_frame(len, 8'(frame_type_cfg ^ $urandom_range(1, 255)), 1'b1, len);
            end else begin
                // Broken frame: the next start byte lands inside the old frame.
                push_frame(len, frame_type_cfg, 1'b1, $urandom_range(0, len - 1));
            end
        end
    endtask

    task automatic send_stream(input int unsigned gap_pct);
        while (rx_stream.size() != 0) begin
            while ($urandom_range(99) < gap_pct) begin
                rx_ch.valid = 1'b0;
                rx_ch.rx_byte = 8'($urandom_range(255));
                @(negedge clk);
            end
            rx_ch.valid = 1'b1;
            rx_ch.rx_byte = rx_stream[0].rx_byte;
            do @(posedge clk); while (!rx_ch.ready);
            @(negedge clk);
        end
        rx_ch.valid = 1'b0;
    endtask

    task automatic run_phase(input int unsigned gap_pct, input int unsigned stall);
        stall_pct = stall;
        send_stream(gap_pct);
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_frame_type(FRAME_TYPE_RESET);
        foreach (directed_rows[i]) rx_stream.push_back(directed_rows[i]);
        fill_traffic(100);
        run_phase(0, 0);

        set_frame_type(8'h00);
        fill_traffic(100);
        push_frame(FRAME_LEN_MAX - 1, 8'h00, 1'b1, FRAME_LEN_MAX - 1);
        run_phase(0, 0);

        set_frame_type(8'hFF);
        fill_traffic(140);
        run_phase(49, 0);

        set_frame_type(8'($urandom_range(255)));
        fill_traffic(140);
        run_phase(0, 49);

        set_frame_type(FRAME_TYPE_RESET);
        fill_traffic(140);
        run_phase(27, 27);

        // Long receiver hold-off with the sender pushing every cycle that ready allows.
        set_frame_type(8'($urandom_range(255)));
        fill_traffic(160);
        hold_off_left = HOLD_OFF_LEN;
        run_phase(0, 20);

        if (error_cnt == 0) begin
            $display("tb_api_frame_deframer passed");
        end else begin
            $display("tb_api_frame_deframer failed");
        end
        $finish;
    end

endmodule

FILE: api_frame_deframer.f
hdl/afd_pkg.sv
hdl/afd_if.sv
hdl/afd_cfg.sv
hdl/afd_in_stage.sv
hdl/afd_parse.sv
hdl/api_frame_deframer.sv
hdl/afd_checker.sv
sim/tb_api_frame_deframer.sv
